FILE: sv/sac_pkg.sv
// ----------------------------------------------------------------------------
// Cache tag store package
// Shared types and constants for the set-associative tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

    localparam int TAG_W   = 32;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int ADDR_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU     = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_WRITE = 4'b1000
    } t_state;

endpackage

FILE: sv/sac_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module sac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/set_assoc_cache_lru_fifo.sv
// ----------------------------------------------------------------------------
// Set-associative cache tag store
// Write-through, write-allocate tag store with LRU or FIFO replacement.
// ----------------------------------------------------------------------------
// Result: registered by the write-back state, which holds while the result
// slot is full. No new access is taken until the read-modify-write of
// the single set row in the line memory (read, compare, write back) is done.
// Reset: control state and totals clear at once; a clearing pass then zeroes
// every set of the line memory, during which no access is taken.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_fifo #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sac_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // access stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,  // address
    input  logic [0:0]                      s_axis_tuser,  // cmd
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [127:0]                    m_axis_tdata,  // hit_total, miss_total, read_total, write_total
    output logic [2:0]                      m_axis_tuser   // hit, mem_read, mem_write
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LVL    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
    localparam int P      = 1 << LVL;
    localparam int ROW_W  = MAX_WAYS * $bits(sac_pkg::t_entry);
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

    typedef sac_pkg::t_entry [MAX_WAYS-1:0] t_row;

    sac_pkg::t_state r_state, n_state;

    logic [3:0] r_index_bits;
    logic [4:0] r_offset_bits;
    logic [3:0] r_ways_used;
    logic       r_use_lru;

    logic [SET_W-1:0]              r_clr;
    logic [SET_W-1:0]              r_set;
    logic [sac_pkg::TAG_W-1:0]     r_tag;
    logic                          r_cmd;
    logic                          r_hit;
    logic [WAY_W-1:0]              r_way;
    logic [sac_pkg::STAMP_W-1:0]   r_top;

    logic [sac_pkg::CNT_W-1:0] r_hits, r_misses, r_reads, r_writes;

    logic         r_out_valid;
    logic [127:0] r_out_data;
    logic [2:0]   r_out_user;

    logic             w_accept;
    logic             w_commit;
    logic [SET_W-1:0] w_set;
    logic [sac_pkg::TAG_W-1:0] w_tag;
    logic [5:0]       w_shift;
    logic [31:0]      w_set_full;
    logic [4:0]       w_ways_eff;
    logic [MAX_WAYS-1:0] w_en;

    logic             w_wr_en;
    logic [SET_W-1:0] w_wr_addr;
    logic [ROW_W-1:0] w_wr_data;
    logic [ROW_W-1:0] w_rd_data;
    t_row             w_row;
    t_row             w_new_row;

    logic                        w_hit;
    logic [WAY_W-1:0]            w_hit_way;
    logic                        w_any_inval;
    logic [WAY_W-1:0]            w_inval_way;
    logic [sac_pkg::STAMP_W-1:0] w_max;
    logic [WAY_W-1:0]            w_min_way;

    logic [sac_pkg::STAMP_W-1:0] w_mx [P];
    logic [sac_pkg::STAMP_W-1:0] w_mn [P];
    logic [WAY_W-1:0]            w_mi [P];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == sac_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = (r_state == sac_pkg::ST_WRITE) && (!r_out_valid || m_axis_tready);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Address decomposition
    assign w_shift    = {2'b00, r_index_bits} + {1'b0, r_offset_bits};
    assign w_tag      = (w_shift >= 6'd32) ? '0 : (s_axis_tdata >> w_shift);
    assign w_set_full = (s_axis_tdata >> r_offset_bits) & ~(32'hFFFF_FFFF << r_index_bits);
    assign w_set      = (MAX_SETS > 1) ? w_set_full[SET_W-1:0] : '0;

    always_comb begin
        if (r_ways_used == 4'd0) begin
            w_ways_eff = 5'd1;
        end else if ({1'b0, r_ways_used} > 5'(MAX_WAYS)) begin
            w_ways_eff = 5'(MAX_WAYS);
        end else begin
            w_ways_eff = {1'b0, r_ways_used};
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            w_en[w] = (5'(w) < w_ways_eff);
        end
    end

    assign w_row = t_row'(w_rd_data);

    // Tag compare and first-free search
    always_comb begin
        w_hit       = 1'b0;
        w_hit_way   = '0;
        w_any_inval = 1'b0;
        w_inval_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (w_en[w] && w_row[w].valid && (w_row[w].tag == r_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (w_en[w] && !w_row[w].valid) begin
                w_any_inval = 1'b1;
                w_inval_way = WAY_W'(w);
            end
        end
    end

    // Highest and lowest stamp trees; the lower way wins ties.
    always_comb begin
        for (int i = 0; i < P; i++) begin
            if (i < MAX_WAYS && w_en[i]) begin
                w_mx[i] = w_row[i].stamp;
                w_mn[i] = w_row[i].stamp;
            end else begin
                w_mx[i] = '0;
                w_mn[i] = '1;
            end
            w_mi[i] = WAY_W'(i);
        end
        for (int lv = 0; lv < LVL; lv++) begin
            for (int i = 0; i < (P >> (lv + 1)); i++) begin
                w_mx[i] = (w_mx[2*i+1] > w_mx[2*i]) ? w_mx[2*i+1] : w_mx[2*i];
                if (w_mn[2*i+1] < w_mn[2*i]) begin
                    w_mn[i] = w_mn[2*i+1];
                    w_mi[i] = w_mi[2*i+1];
                end else begin
                    w_mn[i] = w_mn[2*i];
                    w_mi[i] = w_mi[2*i];
                end
            end
        end
        w_max     = w_mx[0];
        w_min_way = w_mi[0];
    end

    // Row update
    always_comb begin
        w_new_row = w_row;
        if (r_hit) begin
            if (r_use_lru) begin
                w_new_row[r_way].stamp = r_top + 32'd1;
            end
        end else begin
            w_new_row[r_way].valid = 1'b1;
            w_new_row[r_way].tag   = r_tag;
            w_new_row[r_way].stamp = r_top + 32'd1;
        end
    end

    always_comb begin
        if (r_state == sac_pkg::ST_CLEAR) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = w_commit;
            w_wr_addr = r_set;
            w_wr_data = ROW_W'(w_new_row);
        end
    end

    sac_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_set),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sac_pkg::ST_CLEAR: begin
                if (r_clr == LAST_SET) begin
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = sac_pkg::ST_LOOK;
                end
            end
            sac_pkg::ST_LOOK: begin
                n_state = sac_pkg::ST_WRITE;
            end
            sac_pkg::ST_WRITE: begin
                if (w_commit) begin
                    n_state = sac_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sac_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= sac_pkg::ST_CLEAR;
            r_clr         <= '0;
            r_index_bits  <= 4'd0;
            r_offset_bits <= 5'd4;
            r_ways_used   <= 4'd1;
            r_use_lru     <= 1'b1;
            r_hits        <= '0;
            r_misses      <= '0;
            r_reads       <= '0;
            r_writes      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sac_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sac_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[3:0];
                    sac_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[4:0];
                    sac_pkg::CFG_WAYS_USED:   r_ways_used   <= i_cfg_data[3:0];
                    sac_pkg::CFG_USE_LRU:     r_use_lru     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_hit) begin
                    r_hits <= r_hits + 32'd1;
                end else begin
                    r_misses <= r_misses + 32'd1;
                    r_reads  <= r_reads + 32'd1;
                end
                if (r_cmd) begin
                    r_writes <= r_writes + 32'd1;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set <= w_set;
            r_tag <= w_tag;
            r_cmd <= s_axis_tuser[0];
        end
        if (r_state == sac_pkg::ST_LOOK) begin
            r_hit <= w_hit;
            r_way <= w_hit ? w_hit_way : (w_any_inval ? w_inval_way : w_min_way);
            r_top <= w_max;
        end
        if (w_commit) begin
            r_out_user <= {r_cmd, !r_hit, r_hit};
            r_out_data <= {r_writes + 32'(r_cmd),
                           r_reads + 32'(!r_hit),
                           r_misses + 32'(!r_hit),
                           r_hits + 32'(r_hit)};
        end
    end

    a_accept_to_look: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == sac_pkg::ST_LOOK))
        else $error("access did not move to lookup");

    a_write_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sac_pkg::ST_WRITE) && r_out_valid && !m_axis_tready)
        |=> (r_state == sac_pkg::ST_WRITE))
        else $error("write-back left while result slot was full");

    a_no_write_in_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sac_pkg::ST_LOOK) |-> !w_wr_en)
        else $error("line memory written during lookup");

    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> ((r_hits + r_misses) == ($past(r_hits) + $past(r_misses) + 32'd1)))
        else $error("access not counted exactly once");

endmodule
